/* rtl/sbalc_pkg.sv */
// ----------------------------------------------------------------------------
// Subpage bitmap allocator package
// Shared constants and types for the slot allocator and its testbench.
// ----------------------------------------------------------------------------
package sbalc_pkg;

    // Each bitmap memory word covers this many slots.
    localparam int WORD_BITS  = 64;
    localparam int WORD_SHIFT = 6;

    // Fixed widths of the stream fields.
    localparam int REQ_W       = 1;
    localparam int SLOT_W      = 9;
    localparam int ECOUNT_W    = 10;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 24;

    // Element count after reset.
    localparam logic [ECOUNT_W-1:0] ECOUNT_RST = 10'd512;

    // Request kinds carried on s_tuser.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status carried on m_tuser.
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE       = 2'd0,
        ST_ALLOC_FAIL = 2'd1,
        ST_BAD_FREE   = 2'd2,
        ST_RELEASED   = 2'd3
    } status_t;

    // Request sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_EMIT
    } state_t;

endpackage

/* rtl/sbalc_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered on a read enable.
// ----------------------------------------------------------------------------
module sbalc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/subpage_bitmap_allocator.sv */
// ----------------------------------------------------------------------------
// Subpage bitmap allocator
// Slot allocator for the equal-sized elements of one page run.
// ----------------------------------------------------------------------------
// The used-slot bitmap lives in a RAM of 64-bit words with a registered read;
// a full flag per word steers the search for the lowest free slot, and a
// valid bit per word makes a never-written word read as all free, so neither
// reset nor an element count write needs a clearing pass. A free is accepted,
// reads its bitmap word and writes it back, then hands on its result; an
// allocate through the hint or the search does the same, and one whose hint
// slot turns out to be taken rereads the RAM first. Requests rejected on the
// counters alone (allocate when full or released, free out of range) skip the
// RAM. One request is in flight at a time; the finished result sits in the
// output register while the next request is accepted.
// Writing elem_count restarts the allocator and is allowed only when idle.
// ----------------------------------------------------------------------------
module subpage_bitmap_allocator #(
    parameter int MAX_ELEMS = 512
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration: element count.
    input  logic                            cfg_we,
    input  logic [sbalc_pkg::ECOUNT_W-1:0]  cfg_wdata,
    // Request stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [8:0] slot_index, [9] sole_in_pool, [15:10] zero
    input  logic [sbalc_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] req_type
    input  logic [sbalc_pkg::REQ_W-1:0]     s_tuser,
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [8:0] granted_index, [18:9] free_count, [19] joined_pool,
    // [20] left_pool, [23:21] zero
    output logic [sbalc_pkg::M_TDATA_W-1:0] m_tdata,
    // [1:0] status
    output logic [sbalc_pkg::STATUS_W-1:0]  m_tuser
);

    import sbalc_pkg::*;

    localparam int NUM_WORDS = (MAX_ELEMS + WORD_BITS - 1) / WORD_BITS;
    localparam int WI_W      = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
    localparam int IDX_W     = $clog2(MAX_ELEMS);
    localparam int CNT_W     = $clog2(MAX_ELEMS + 1);

    // Element count clamped to the bitmap size.
    function automatic logic [CNT_W-1:0] eff_of(input logic [ECOUNT_W-1:0] v);
        if (32'(v) > 32'(MAX_ELEMS)) begin
            return CNT_W'(MAX_ELEMS);
        end
        return CNT_W'(v);
    endfunction

    // Bitmap word that holds a slot.
    function automatic logic [WI_W-1:0] word_of(input logic [31:0] idx);
        return WI_W'(idx >> WORD_SHIFT);
    endfunction

    // Full flags for a fresh start: words wholly beyond the count are full.
    function automatic logic [NUM_WORDS-1:0] full_init(input logic [CNT_W-1:0] cnt);
        logic [NUM_WORDS-1:0] f;
        for (int w = 0; w < NUM_WORDS; w++) begin
            f[w] = (32'(w) * WORD_BITS) >= 32'(cnt);
        end
        return f;
    endfunction

    // State and control registers.
    state_t                 state_reg, state_next;
    logic [ECOUNT_W-1:0]    ecount_reg, ecount_next;
    logic [CNT_W-1:0]       avail_reg, avail_next;
    logic [IDX_W-1:0]       hint_reg, hint_next;
    logic                   hint_valid_reg, hint_valid_next;
    logic                   released_reg, released_next;
    logic [NUM_WORDS-1:0]   full_reg, full_next;
    logic [NUM_WORDS-1:0]   wvalid_reg, wvalid_next;
    logic                   rd_valid_reg, rd_valid_next;

    // Request held while in flight.
    logic                   req_free_reg, req_free_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic                   sole_reg, sole_next;
    logic [WI_W-1:0]        addr_reg, addr_next;
    logic                   search_reg, search_next;

    // Staged result.
    status_t                res_status_reg, res_status_next;
    logic [SLOT_W-1:0]      res_index_reg, res_index_next;
    logic                   res_join_reg, res_join_next;
    logic                   res_leave_reg, res_leave_next;

    // Output register.
    logic                   m_valid_reg, m_valid_next;
    status_t                m_status_reg, m_status_next;
    logic [SLOT_W-1:0]      m_index_reg, m_index_next;
    logic [ECOUNT_W-1:0]    m_free_reg, m_free_next;
    logic                   m_join_reg, m_join_next;
    logic                   m_leave_reg, m_leave_next;

    // RAM ports.
    logic                   ram_wr_en;
    logic [WORD_BITS-1:0]   ram_wr_data;
    logic                   ram_rd_en;
    logic [WI_W-1:0]        ram_rd_addr;
    logic [WORD_BITS-1:0]   ram_rd_data;

    // Lookup helpers.
    logic [CNT_W-1:0]       count;
    logic                   any_open;
    logic [WI_W-1:0]        first_open;
    logic [WORD_BITS-1:0]   word;
    logic [WORD_BITS-1:0]   slot_mask;
    logic [WORD_BITS-1:0]   new_word;
    logic                   bit_found;
    logic [WORD_SHIFT-1:0]  bit_pos;
    logic [WORD_SHIFT-1:0]  look_pos;
    logic [CNT_W-1:0]       avail_inc;

    sbalc_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_bitmap (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (addr_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign count = eff_of(ecount_reg);

    // Lowest word that still has a free slot below the count.
    always_comb begin
        any_open   = 1'b0;
        first_open = '0;
        for (int w = NUM_WORDS - 1; w >= 0; w--) begin
            if (!full_reg[w]) begin
                any_open   = 1'b1;
                first_open = WI_W'(w);
            end
        end
    end

    // Word under inspection, its in-range slots and its lowest free slot.
    always_comb begin
        word      = rd_valid_reg ? ram_rd_data : '0;
        bit_found = 1'b0;
        bit_pos   = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            slot_mask[b] = (32'(addr_reg) * WORD_BITS + 32'(b)) < 32'(count);
        end
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (slot_mask[b] && !word[b]) begin
                bit_found = 1'b1;
                bit_pos   = WORD_SHIFT'(b);
            end
        end
    end

    assign look_pos  = req_free_reg ? slot_reg[WORD_SHIFT-1:0] : hint_reg[WORD_SHIFT-1:0];
    assign avail_inc = avail_reg + CNT_W'(1);

    // Sequencer: next state, bitmap access and state updates.
    always_comb begin
        state_next      = state_reg;
        ecount_next     = ecount_reg;
        avail_next      = avail_reg;
        hint_next       = hint_reg;
        hint_valid_next = hint_valid_reg;
        released_next   = released_reg;
        full_next       = full_reg;
        wvalid_next     = wvalid_reg;
        rd_valid_next   = rd_valid_reg;
        req_free_next   = req_free_reg;
        slot_next       = slot_reg;
        sole_next       = sole_reg;
        addr_next       = addr_reg;
        search_next     = search_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_join_next   = res_join_reg;
        res_leave_next  = res_leave_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_index_next    = m_index_reg;
        m_free_next     = m_free_reg;
        m_join_next     = m_join_reg;
        m_leave_next    = m_leave_reg;
        ram_wr_en       = 1'b0;
        ram_wr_data     = word;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = '0;
        new_word        = word;
        s_tready        = 1'b0;

        // The output beat leaves when the sink takes it.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    req_free_next   = s_tuser[0];
                    slot_next       = s_tdata[SLOT_W-1:0];
                    sole_next       = s_tdata[SLOT_W];
                    res_status_next = ST_DONE;
                    res_index_next  = '0;
                    res_join_next   = 1'b0;
                    res_leave_next  = 1'b0;
                    search_next     = 1'b0;
                    state_next      = S_EMIT;
                    if (s_tuser[0] == REQ_FREE) begin
                        // Out-of-range free is rejected without a read.
                        if (32'(s_tdata[SLOT_W-1:0]) >= 32'(count)) begin
                            res_status_next = ST_BAD_FREE;
                        end else begin
                            ram_rd_addr = word_of(32'(s_tdata[SLOT_W-1:0]));
                            ram_rd_en   = 1'b1;
                            state_next  = S_LOOK;
                        end
                    end else if (avail_reg == '0 || released_reg) begin
                        res_status_next = ST_ALLOC_FAIL;
                    end else begin
                        // The hint is spent by any allocate that gets this far.
                        hint_valid_next = 1'b0;
                        if (hint_valid_reg && (32'(hint_reg) < 32'(count))) begin
                            ram_rd_addr = word_of(32'(hint_reg));
                            ram_rd_en   = 1'b1;
                            state_next  = S_LOOK;
                        end else if (any_open) begin
                            ram_rd_addr = first_open;
                            ram_rd_en   = 1'b1;
                            search_next = 1'b1;
                            state_next  = S_LOOK;
                        end else begin
                            res_status_next = ST_ALLOC_FAIL;
                        end
                    end
                end
            end

            S_LOOK: begin
                state_next = S_EMIT;
                if (req_free_reg) begin
                    // Free: the slot must be in use.
                    if (!word[look_pos]) begin
                        res_status_next = ST_BAD_FREE;
                    end else begin
                        new_word[look_pos] = 1'b0;
                        ram_wr_en          = 1'b1;
                        hint_next          = IDX_W'(slot_reg);
                        hint_valid_next    = 1'b1;
                        if (avail_reg == '0) begin
                            avail_next    = avail_inc;
                            res_join_next = 1'b1;
                        end else begin
                            avail_next = avail_inc;
                            if (avail_inc == count && !sole_reg) begin
                                released_next   = 1'b1;
                                res_status_next = ST_RELEASED;
                                res_leave_next  = 1'b1;
                            end
                        end
                    end
                end else if (!search_reg) begin
                    // Allocate through the hint, or fall back to the search.
                    if (!word[look_pos]) begin
                        new_word[look_pos] = 1'b1;
                        ram_wr_en          = 1'b1;
                        avail_next         = avail_reg - CNT_W'(1);
                        res_index_next     = SLOT_W'(hint_reg);
                        res_leave_next     = (avail_reg == CNT_W'(1));
                    end else if (any_open) begin
                        ram_rd_addr = first_open;
                        ram_rd_en   = 1'b1;
                        search_next = 1'b1;
                        state_next  = S_LOOK;
                    end else begin
                        res_status_next = ST_ALLOC_FAIL;
                    end
                end else begin
                    // Allocate the lowest free slot of the searched word.
                    if (bit_found) begin
                        new_word[bit_pos] = 1'b1;
                        ram_wr_en         = 1'b1;
                        avail_next        = avail_reg - CNT_W'(1);
                        res_index_next    = SLOT_W'(32'(addr_reg) * WORD_BITS
                                                    + 32'(bit_pos));
                        res_leave_next    = (avail_reg == CNT_W'(1));
                    end else begin
                        res_status_next = ST_ALLOC_FAIL;
                    end
                end
                ram_wr_data = new_word;
                if (ram_wr_en) begin
                    wvalid_next[addr_reg] = 1'b1;
                    full_next[addr_reg]   = &(new_word | ~slot_mask);
                end
            end

            S_EMIT: begin
                // Hand the result to the output register once it is free.
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_index_next  = res_index_reg;
                    m_free_next   = ECOUNT_W'(avail_reg);
                    m_join_next   = res_join_reg;
                    m_leave_next  = res_leave_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Latch whether the word being read was ever written.
        if (ram_rd_en) begin
            addr_next     = ram_rd_addr;
            rd_valid_next = wvalid_reg[ram_rd_addr];
        end

        // An element count write restarts the allocator.
        if (cfg_we) begin
            ecount_next     = cfg_wdata;
            avail_next      = eff_of(cfg_wdata);
            hint_next       = '0;
            hint_valid_next = 1'b1;
            released_next   = 1'b0;
            wvalid_next     = '0;
            full_next       = full_init(eff_of(cfg_wdata));
        end
    end

    // Control registers with synchronous reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            ecount_reg     <= ECOUNT_RST;
            avail_reg      <= eff_of(ECOUNT_RST);
            hint_reg       <= '0;
            hint_valid_reg <= 1'b1;
            released_reg   <= 1'b0;
            full_reg       <= full_init(eff_of(ECOUNT_RST));
            wvalid_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ecount_reg     <= ecount_next;
            avail_reg      <= avail_next;
            hint_reg       <= hint_next;
            hint_valid_reg <= hint_valid_next;
            released_reg   <= released_next;
            full_reg       <= full_next;
            wvalid_reg     <= wvalid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        rd_valid_reg   <= rd_valid_next;
        req_free_reg   <= req_free_next;
        slot_reg       <= slot_next;
        sole_reg       <= sole_next;
        addr_reg       <= addr_next;
        search_reg     <= search_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_join_reg   <= res_join_next;
        res_leave_reg  <= res_leave_next;
        m_status_reg   <= m_status_next;
        m_index_reg    <= m_index_next;
        m_free_reg     <= m_free_next;
        m_join_reg     <= m_join_next;
        m_leave_reg    <= m_leave_next;
    end

    // Result beat.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_leave_reg, m_join_reg, m_free_reg, m_index_reg};
    assign m_tuser  = m_status_reg;

endmodule

/* tb/subpage_bitmap_allocator_tb.sv */
// ----------------------------------------------------------------------------
// Subpage bitmap allocator testbench
// Drives allocate and free requests through the request stream, walks the
// element count through several settings, and checks every result beat
// field by field against the directed table or a behavioral model of the
// slot bitmap, the free count, the last-freed hint and the released flag. Both
// stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module subpage_bitmap_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sbalc_pkg::*;

    localparam int SLOTS         = 512;
    localparam int HANG_LIMIT    = 2000;
    localparam int PHASE_ITEMS   = 75;
    localparam int MAX_PRINTS    = 60;

    // One result beat as the model sees it.
    typedef struct {
        status_t        status;
        logic [8:0]     granted;
        logic [9:0]     free_count;
        logic           joined;
        logic           left;
    } result_t;

    typedef enum logic {
        STEP_REQ,
        STEP_CFG
    } step_kind_t;

    // One row of the directed table.
    typedef struct {
        step_kind_t     kind;
        logic           req;
        logic [8:0]     slot;
        logic           sole;
        logic [9:0]     count;
        bit             typed;
        result_t        want;
    } step_t;

    localparam result_t ANY = '{ST_DONE, 9'd0, 10'd0, 1'b0, 1'b0};

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [ECOUNT_W-1:0]    cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [REQ_W-1:0]       s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]    m_tuser;

    // Model state of the allocator.
    logic [9:0]         elem_reg;
    bit [SLOTS-1:0]     slot_taken;
    int unsigned        avail;
    int unsigned        hint_slot;
    bit                 hint_ok;
    bit                 pool_released;

    result_t            expected_results[$];
    step_t              steps[$];
    int                 err_count = 0;
    int                 idle_cycles = 0;
    bit                 s_calm = 1'b0;

    subpage_bitmap_allocator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Free-running clock.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Counts above the slot capacity behave as the capacity.
    function automatic int unsigned usable_slots();
        return (elem_reg > SLOTS) ? SLOTS : int'(elem_reg);
    endfunction

    // Reset and count writes both start the allocator from scratch.
    function automatic void restart_allocator(logic [9:0] count);
        elem_reg      = count;
        slot_taken    = '0;
        avail         = usable_slots();
        hint_slot     = 0;
        hint_ok       = 1'b1;
        pool_released = 1'b0;
    endfunction

    // Applies one request to the model and returns the beat it should produce.
    function automatic result_t predict_request(logic req, logic [8:0] slot, logic sole);
        result_t        r;
        int unsigned    cnt;
        int unsigned    pick;
        int unsigned    k;
        bit             found;
        cnt   = usable_slots();
        r     = ANY;
        pick  = 0;
        found = 1'b0;
        if (req == REQ_ALLOC) begin
            if (avail == 0 || pool_released) begin
                r.status = ST_ALLOC_FAIL;
            end else begin
                if (hint_ok && hint_slot < cnt && !slot_taken[hint_slot]) begin
                    pick  = hint_slot;
                    found = 1'b1;
                end
                hint_ok = 1'b0;
                for (k = 0; k < cnt && !found; k++) begin
                    if (!slot_taken[k]) begin
                        pick  = k;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    r.status = ST_ALLOC_FAIL;
                end else begin
                    slot_taken[pick] = 1'b1;
                    avail--;
                    r.granted = pick[8:0];
                    r.left    = (avail == 0);
                end
            end
        end else if (slot >= cnt || !slot_taken[slot]) begin
            r.status = ST_BAD_FREE;
        end else begin
            slot_taken[slot] = 1'b0;
            hint_slot = slot;
            hint_ok   = 1'b1;
            if (avail == 0) begin
                // A full allocator rejoins the pool on its first free.
                avail    = 1;
                r.joined = 1'b1;
            end else begin
                avail++;
                if (avail == cnt && !sole) begin
                    pool_released = 1'b1;
                    r.status      = ST_RELEASED;
                    r.left        = 1'b1;
                end
            end
        end
        r.free_count = avail[9:0];
        return r;
    endfunction

    // Picks a taken slot, so that most frees are legal.
    function automatic logic [8:0] pick_taken_slot(int unsigned cnt);
        int unsigned start;
        int unsigned k;
        int unsigned idx;
        start = $urandom_range(0, cnt - 1);
        for (k = 0; k < cnt; k++) begin
            idx = (start + k) % cnt;
            if (slot_taken[idx]) begin
                return idx[8:0];
            end
        end
        return 9'($urandom_range(0, SLOTS - 1));
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        if (err_count < MAX_PRINTS) begin
            $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        end
        err_count++;
    endtask

    // Sends one request beat and records what it should produce.
    task automatic issue_request(logic req, logic [8:0] slot, logic sole, bit typed,
                                 result_t want);
        int         gap;
        result_t    pred;
        gap = s_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - 10){1'b0}}, sole, slot};
        s_tuser  <= req;
        do @(posedge aclk); while (s_tready !== 1'b1);
        pred = predict_request(req, slot, sole);
        expected_results.push_back(typed ? want : pred);
    endtask

    // Count writes happen only once the block has drained.
    task automatic write_elem_count(logic [9:0] count);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        restart_allocator(count);
    endtask

    // Result side: random stalls, with calm stretches in between.
    initial begin
        int stall;
        int run_left;
        bit calm;
        calm     = 1'b0;
        run_left = 0;
        forever begin
            if (run_left == 0) begin
                calm     = ($urandom_range(0, 2) == 0);
                run_left = $urandom_range(10, 60);
            end
            run_left--;
            stall = calm ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    // Compare each result beat with the oldest expectation.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected beat", m_tdata[15:0], 16'd0);
            end else begin
                want = expected_results.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", 16'(m_tuser), 16'(want.status));
                if (m_tdata[8:0] !== want.granted)
                    report_mismatch("granted_index", 16'(m_tdata[8:0]), 16'(want.granted));
                if (m_tdata[18:9] !== want.free_count)
                    report_mismatch("free_count", 16'(m_tdata[18:9]), 16'(want.free_count));
                if (m_tdata[19] !== want.joined)
                    report_mismatch("joined_pool", 16'(m_tdata[19]), 16'(want.joined));
                if (m_tdata[20] !== want.left)
                    report_mismatch("left_pool", 16'(m_tdata[20]), 16'(want.left));
            end
        end
    end

    // Watchdog on cycles without any accepted beat or register write.
    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= HANG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Stimulus and verdict.
    initial begin
        int unsigned    phase_counts[12];
        step_t          st;
        int unsigned    cnt;
        int             alloc_pct;
        int             pick;
        logic           req;
        logic [8:0]     slot;

        phase_counts = '{3, 1, 64, 0, 2, 100, 1023, 65, 7, 513, 512, 0};

        // Directed table; typed results are read straight off the behavior.
        steps.push_back('{STEP_REQ, REQ_ALLOC, 9'd0,   1'b0, 10'd0,
                          1'b1, '{ST_DONE, 9'd0, 10'd511, 1'b0, 1'b0}});
        steps.push_back('{STEP_REQ, REQ_ALLOC, 9'd0,   1'b0, 10'd0,
                          1'b1, '{ST_DONE, 9'd1, 10'd510, 1'b0, 1'b0}});
        steps.push_back('{STEP_REQ, REQ_FREE,  9'd511, 1'b0, 10'd0,
                          1'b1, '{ST_BAD_FREE, 9'd0, 10'd510, 1'b0, 1'b0}});
        steps.push_back('{STEP_REQ, REQ_FREE,  9'd0,   1'b0, 10'd0,
                          1'b1, '{ST_DONE, 9'd0, 10'd511, 1'b0, 1'b0}});
        steps.push_back('{STEP_REQ, REQ_ALLOC, 9'd511, 1'b1, 10'd0,
                          1'b1, '{ST_DONE, 9'd0, 10'd510, 1'b0, 1'b0}});
        // Single-element run: full on its first allocate, never released.
        steps.push_back('{STEP_CFG, REQ_ALLOC, 9'd0,   1'b0, 10'd1,    1'b0, ANY});
        steps.push_back('{STEP_REQ, REQ_ALLOC, 9'd0,   1'b0, 10'd0,
                          1'b1, '{ST_DONE, 9'd0, 10'd0, 1'b0, 1'b1}});
        steps.push_back('{STEP_REQ, REQ_ALLOC, 9'd0,   1'b0, 10'd0,
                          1'b1, '{ST_ALLOC_FAIL, 9'd0, 10'd0, 1'b0, 1'b0}});
        steps.push_back('{STEP_REQ, REQ_FREE,  9'd0,   1'b0, 10'd0,
                          1'b1, '{ST_DONE, 9'd0, 10'd1, 1'b1, 1'b0}});
        steps.push_back('{STEP_REQ, REQ_FREE,  9'd1,   1'b1, 10'd0,
                          1'b1, '{ST_BAD_FREE, 9'd0, 10'd1, 1'b0, 1'b0}});
        // Empty run: nothing can be allocated or freed.
        steps.push_back('{STEP_CFG, REQ_ALLOC, 9'd0,   1'b0, 10'd0,    1'b0, ANY});
        steps.push_back('{STEP_REQ, REQ_ALLOC, 9'd0,   1'b0, 10'd0,
                          1'b1, '{ST_ALLOC_FAIL, 9'd0, 10'd0, 1'b0, 1'b0}});
        steps.push_back('{STEP_REQ, REQ_FREE,  9'd0,   1'b0, 10'd0,
                          1'b1, '{ST_BAD_FREE, 9'd0, 10'd0, 1'b0, 1'b0}});
        // Two elements: fill, rejoin, then release when wholly empty.
        steps.push_back('{STEP_CFG, REQ_ALLOC, 9'd0,   1'b0, 10'd2,    1'b0, ANY});
        steps.push_back('{STEP_REQ, REQ_ALLOC, 9'd0,   1'b0, 10'd0,
                          1'b1, '{ST_DONE, 9'd0, 10'd1, 1'b0, 1'b0}});
        steps.push_back('{STEP_REQ, REQ_ALLOC, 9'd0,   1'b0, 10'd0,
                          1'b1, '{ST_DONE, 9'd1, 10'd0, 1'b0, 1'b1}});
        steps.push_back('{STEP_REQ, REQ_FREE,  9'd1,   1'b1, 10'd0,
                          1'b1, '{ST_DONE, 9'd0, 10'd1, 1'b1, 1'b0}});
        steps.push_back('{STEP_REQ, REQ_FREE,  9'd0,   1'b0, 10'd0,
                          1'b1, '{ST_RELEASED, 9'd0, 10'd2, 1'b0, 1'b1}});
        steps.push_back('{STEP_REQ, REQ_ALLOC, 9'd0,   1'b0, 10'd0,
                          1'b1, '{ST_ALLOC_FAIL, 9'd0, 10'd2, 1'b0, 1'b0}});
        steps.push_back('{STEP_REQ, REQ_FREE,  9'd0,   1'b0, 10'd0,
                          1'b1, '{ST_BAD_FREE, 9'd0, 10'd2, 1'b0, 1'b0}});
        // Count above capacity behaves as the full 512.
        steps.push_back('{STEP_CFG, REQ_ALLOC, 9'd0,   1'b0, 10'd1023, 1'b0, ANY});
        steps.push_back('{STEP_REQ, REQ_ALLOC, 9'd0,   1'b0, 10'd0,
                          1'b1, '{ST_DONE, 9'd0, 10'd511, 1'b0, 1'b0}});
        steps.push_back('{STEP_REQ, REQ_FREE,  9'd511, 1'b1, 10'd0,
                          1'b1, '{ST_BAD_FREE, 9'd0, 10'd511, 1'b0, 1'b0}});
        steps.push_back('{STEP_REQ, REQ_FREE,  9'd0,   1'b1, 10'd0,
                          1'b1, '{ST_DONE, 9'd0, 10'd512, 1'b0, 1'b0}});
        steps.push_back('{STEP_REQ, REQ_ALLOC, 9'd0,   1'b0, 10'd0,    1'b0, ANY});
        steps.push_back('{STEP_REQ, REQ_ALLOC, 9'd300, 1'b1, 10'd0,    1'b0, ANY});
        steps.push_back('{STEP_REQ, REQ_FREE,  9'd1,   1'b0, 10'd0,    1'b0, ANY});

        // Start in reset, then release it.
        restart_allocator(ECOUNT_RST);
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table.
        foreach (steps[i]) begin
            st = steps[i];
            if (st.kind == STEP_CFG) begin
                write_elem_count(st.count);
            end else begin
                issue_request(st.req, st.slot, st.sole, st.typed, st.want);
            end
        end

        // Random phases, each under its own element count.
        phase_counts[11] = $urandom_range(1, 1023);
        foreach (phase_counts[p]) begin
            write_elem_count(phase_counts[p][9:0]);
            alloc_pct = $urandom_range(30, 90);
            s_calm    = ($urandom_range(0, 2) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                cnt  = usable_slots();
                req  = ($urandom_range(0, 99) < alloc_pct) ? REQ_ALLOC : REQ_FREE;
                slot = 9'($urandom_range(0, SLOTS - 1));
                if (req == REQ_FREE && cnt > 0) begin
                    // Mostly legal frees, some in range but loose, some wild.
                    pick = $urandom_range(0, 9);
                    if (pick < 8) begin
                        slot = pick_taken_slot(cnt);
                    end else if (pick == 8) begin
                        slot = 9'($urandom_range(0, cnt - 1));
                    end
                end
                if ($urandom_range(0, 15) == 0) begin
                    s_calm = !s_calm;
                end
                issue_request(req, slot, ($urandom_range(0, 3) == 0), 1'b0, ANY);
            end
        end

        // Drain and decide.
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* subpage_bitmap_allocator.f */
rtl/sbalc_pkg.sv
rtl/sbalc_ram.sv
rtl/subpage_bitmap_allocator.sv
tb/subpage_bitmap_allocator_tb.sv
